### rtl/core/track_matte_pixel_unit_core_macros.svh
// Assertion macros shared by the track matte pixel unit RTL.
// Each macro expects clk and arst_n in scope.
`ifndef TRACK_MATTE_PIXEL_UNIT_CORE_MACROS_SVH
`define TRACK_MATTE_PIXEL_UNIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmpu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMPU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmpu assertion failed");

`endif

### rtl/core/tmpu_pkg.sv
`timescale 1ns / 1ps

package tmpu_pkg;

	localparam int CH_W = 16;
	localparam logic [CH_W-1:0] CH_FULL = {CH_W{1'b1}};
	localparam logic [CH_W-1:0] CH_HALF = CH_FULL >> 1;

	// Rec.709 luma weights in units of 1/10000.
	localparam int LUMA_COEF_W = 13;
	localparam logic [LUMA_COEF_W-1:0] LUMA_R = 13'd2126;
	localparam logic [LUMA_COEF_W-1:0] LUMA_G = 13'd7152;
	localparam logic [LUMA_COEF_W-1:0] LUMA_B = 13'd722;

	// Weighted sum plus rounding bias stays below 10000 * 2^CH_W.
	localparam int LUMA_SUM_W = CH_W + 14;
	localparam logic [LUMA_SUM_W-1:0] LUMA_BIAS = LUMA_SUM_W'(5000);

	// Division by 10000 as a multiply by ceil(2^43 / 10000) and a shift.
	// The error term times the largest sum stays below 2^43, so the quotient is exact.
	localparam int LUMA_RECIP_W = 30;
	localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 30'd879609303;
	localparam int LUMA_RECIP_SHIFT = 43;
	localparam int LUMA_PROD_W = LUMA_SUM_W + LUMA_RECIP_W;

	typedef enum logic [2:0] {
		MODE_NONE      = 3'd0,
		MODE_ALPHA     = 3'd1,
		MODE_INV_ALPHA = 3'd2,
		MODE_LUMA      = 3'd3,
		MODE_INV_LUMA  = 3'd4
	} matte_mode_t;

	typedef logic [3:0][CH_W-1:0] pixel_t;
	typedef logic [2*CH_W-1:0] wide_t;

	typedef struct packed {
		logic apply;
		logic use_luma;
		logic invert;
	} ctl_t;

	// Quotient of x / CH_FULL for x below 2^(2*CH_W). Since 2^CH_W = CH_FULL + 1,
	// x = q0 * CH_FULL + (low + q0), and the remainder is at most 2 * CH_FULL.
	function automatic logic [CH_W-1:0] div_full(input wide_t x);
		logic [CH_W-1:0] q0;
		logic [CH_W:0]   rem;
		q0  = x[2*CH_W-1:CH_W];
		rem = {1'b0, x[CH_W-1:0]} + {1'b0, q0};
		return q0 + CH_W'(rem >= {1'b0, CH_FULL});
	endfunction

endpackage

### rtl/core/track_matte_pixel_unit_core.sv
`timescale 1ns / 1ps
`include "track_matte_pixel_unit_core_macros.svh"

// Track matte pixel unit: weights each layer pixel (premultiplied RGBA, Q0.16 with 65535
// as 1.0) by a factor taken from the matching mask pixel: the mask alpha, its inverse, the
// Rec.709 luma of the mask color times its alpha, or the inverse of that, as selected by
// the mode register (0 none, 1 alpha, 2 inverted alpha, 3 luma, 4 inverted luma; codes 5
// to 7 act as none). With mode none, or when the overlap flag in tuser is low, the pixel
// passes through unchanged. The datapath is a seven-stage pipeline (luma products, luma
// sum, reciprocal divide, luma times alpha, weight select, channel products, rounding
// divide and output register); a new word is taken every cycle, and a stall on the output
// holds the whole pipeline. Write the mode only while no words are in flight.
module track_matte_pixel_unit_core
	import tmpu_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [2:0]          cfg_wdata,  // matte_mode
	input  logic                s_tvalid,
	output logic                s_tready,
	// layer_red, layer_green, layer_blue, layer_alpha,
	// matte_red, matte_green, matte_blue, matte_alpha
	input  logic [8*CH_W-1:0]   s_tdata,
	input  logic                s_tuser,    // inside_overlap
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [4*CH_W-1:0]   m_tdata     // out_red, out_green, out_blue, out_alpha
);

	logic [2:0] mode_q;
	logic       en;
	ctl_t       ctl_in;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic [6:0] stage_vld;

	pixel_t                  px_s1, px_s2, px_s3, px_s4, px_s5, px_s6;
	pixel_t                  out_s7;
	logic [CH_W-1:0]         ma_s1, ma_s2, ma_s3, ma_s4;
	ctl_t                    ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic                    apply_s5, apply_s6;
	logic [LUMA_SUM_W-1:0]   pr_s1, pg_s1, pb_s1;
	logic [LUMA_SUM_W-1:0]   sum_s2;
	logic [LUMA_PROD_W-1:0]  lprod_s3;
	wide_t                   lm_s4;
	logic [CH_W-1:0]         weight_s5;
	wide_t [3:0]             prod_s6;

	logic [LUMA_PROD_W-LUMA_RECIP_SHIFT-1:0] luma_raw;
	logic [CH_W-1:0]                         luma_sat;
	logic [CH_W-1:0]                         lw;

	pixel_t          in_layer;
	logic [CH_W-1:0] in_mr, in_mg, in_mb, in_ma;

	assign in_layer = s_tdata[4*CH_W-1:0];
	assign in_mr    = s_tdata[5*CH_W-1:4*CH_W];
	assign in_mg    = s_tdata[6*CH_W-1:5*CH_W];
	assign in_mb    = s_tdata[7*CH_W-1:6*CH_W];
	assign in_ma    = s_tdata[8*CH_W-1:7*CH_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
		end else if (cfg_wen) begin
			mode_q <= cfg_wdata;
		end
	end

	// The whole pipeline advances together unless the output word is held.
	assign en       = !valid_s7 || m_tready;
	assign s_tready = en;
	assign m_tvalid = valid_s7;
	assign m_tdata  = out_s7;

	always_comb begin
		case (mode_q)
			MODE_ALPHA:     ctl_in = '{apply: s_tuser, use_luma: 1'b0, invert: 1'b0};
			MODE_INV_ALPHA: ctl_in = '{apply: s_tuser, use_luma: 1'b0, invert: 1'b1};
			MODE_LUMA:      ctl_in = '{apply: s_tuser, use_luma: 1'b1, invert: 1'b0};
			MODE_INV_LUMA:  ctl_in = '{apply: s_tuser, use_luma: 1'b1, invert: 1'b1};
			default:        ctl_in = '{apply: 1'b0, use_luma: 1'b0, invert: 1'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	assign stage_vld = {valid_s7, valid_s6, valid_s5, valid_s4, valid_s3, valid_s2, valid_s1};

	// Luma is rounded and saturated; the reciprocal product keeps it within range.
	assign luma_raw = lprod_s3[LUMA_PROD_W-1:LUMA_RECIP_SHIFT];
	assign luma_sat = (luma_raw > (LUMA_PROD_W-LUMA_RECIP_SHIFT)'(CH_FULL)) ? CH_FULL
		: luma_raw[CH_W-1:0];
	assign lw = div_full(lm_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: constant luma products.
			px_s1  <= in_layer;
			ma_s1  <= in_ma;
			ctl_s1 <= ctl_in;
			pr_s1  <= LUMA_SUM_W'(LUMA_R) * LUMA_SUM_W'(in_mr);
			pg_s1  <= LUMA_SUM_W'(LUMA_G) * LUMA_SUM_W'(in_mg);
			pb_s1  <= LUMA_SUM_W'(LUMA_B) * LUMA_SUM_W'(in_mb);

			// Stage 2: luma sum with rounding bias.
			px_s2  <= px_s1;
			ma_s2  <= ma_s1;
			ctl_s2 <= ctl_s1;
			sum_s2 <= pr_s1 + pg_s1 + pb_s1 + LUMA_BIAS;

			// Stage 3: divide by 10000 through the reciprocal.
			px_s3    <= px_s2;
			ma_s3    <= ma_s2;
			ctl_s3   <= ctl_s2;
			lprod_s3 <= LUMA_PROD_W'(sum_s2) * LUMA_PROD_W'(LUMA_RECIP);

			// Stage 4: luma times mask alpha, with rounding term.
			px_s4  <= px_s3;
			ma_s4  <= ma_s3;
			ctl_s4 <= ctl_s3;
			lm_s4  <= wide_t'(luma_sat) * wide_t'(ma_s3) + wide_t'(CH_HALF);

			// Stage 5: weight select.
			px_s5    <= px_s4;
			apply_s5 <= ctl_s4.apply;
			if (ctl_s4.use_luma) begin
				weight_s5 <= ctl_s4.invert ? CH_FULL - lw : lw;
			end else begin
				weight_s5 <= ctl_s4.invert ? CH_FULL - ma_s4 : ma_s4;
			end

			// Stage 6: channel products.
			px_s6    <= px_s5;
			apply_s6 <= apply_s5;
			for (int i = 0; i < 4; i++) begin
				prod_s6[i] <= wide_t'(px_s5[i]) * wide_t'(weight_s5) + wide_t'(CH_HALF);
			end

			// Stage 7: rounding divide and output register.
			for (int i = 0; i < 4; i++) begin
				out_s7[i] <= apply_s6 ? div_full(prod_s6[i]) : px_s6[i];
			end
		end
	end

	`TMPU_ASSERT_NXT(a_stall_holds_pipe, !en, $stable(stage_vld))
	`TMPU_ASSERT_NXT(a_pass_through, valid_s6 && en && !apply_s6, m_tdata == $past(px_s6))
	`TMPU_ASSERT_IMP(a_luma_in_range, valid_s3, luma_raw <= (LUMA_PROD_W-LUMA_RECIP_SHIFT)'(CH_FULL))
	`TMPU_ASSERT_IMP(a_out_from_s6, $rose(m_tvalid), $past(valid_s6))

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import tmpu_pkg::*;

	localparam logic [CH_W-1:0] CHAN_FULL = {CH_W{1'b1}};
	localparam logic [31:0] LUMA_RED_COEF = 32'd2126;
	localparam logic [31:0] LUMA_GREEN_COEF = 32'd7152;
	localparam logic [31:0] LUMA_BLUE_COEF = 32'd722;
	localparam logic [31:0] LUMA_DIVISOR = 32'd10000;
	localparam int MODE_CODES = 8;
	localparam int PIPE_DRAIN = 12;
	localparam int CH_RED = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE = 2;
	localparam int CH_ALPHA = 3;

	typedef struct packed {
		logic   overlap;
		pixel_t matte;
		pixel_t layer;
	} matte_item_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [2:0]          cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [8*CH_W-1:0]   s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [4*CH_W-1:0]   m_tdata;

	pixel_t      expected_pixels[$];
	logic [2:0]  active_mode = MODE_NONE;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          error_count = 0;
	int          pixels_checked = 0;
	int          segment_count = 0;
	string       chan_name[4] = '{"red", "green", "blue", "alpha"};

	track_matte_pixel_unit_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Q0.16 product, rounded to nearest.
	function automatic logic [CH_W-1:0] q16_mul(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		logic [32:0] prod;
		prod = 33'(a) * 33'(b) + 33'(CHAN_FULL >> 1);
		return CH_W'(prod / 33'(CHAN_FULL));
	endfunction

	function automatic logic [CH_W-1:0] rec709_luma(input pixel_t m);
		logic [31:0] weighted_sum;
		logic [31:0] quotient;
		weighted_sum = LUMA_RED_COEF * 32'(m[CH_RED]) + LUMA_GREEN_COEF * 32'(m[CH_GREEN])
			+ LUMA_BLUE_COEF * 32'(m[CH_BLUE]);
		quotient = (weighted_sum + LUMA_DIVISOR / 2) / LUMA_DIVISOR;
		if (quotient > 32'(CHAN_FULL)) begin
			quotient = 32'(CHAN_FULL);
		end
		return CH_W'(quotient);
	endfunction

	function automatic pixel_t weight_layer_pixel(input matte_item_t item,
			input logic [2:0] mode);
		logic [CH_W-1:0] weight;
		logic            apply;
		pixel_t          result;
		apply = 1'b1;
		weight = CHAN_FULL;
		case (mode)
			MODE_ALPHA: weight = item.matte[CH_ALPHA];
			MODE_INV_ALPHA: weight = CHAN_FULL - item.matte[CH_ALPHA];
			MODE_LUMA: weight = q16_mul(rec709_luma(item.matte), item.matte[CH_ALPHA]);
			MODE_INV_LUMA: begin
				weight = CHAN_FULL - q16_mul(rec709_luma(item.matte), item.matte[CH_ALPHA]);
			end
			default: apply = 1'b0;
		endcase
		if (!item.overlap) begin
			apply = 1'b0;
		end
		for (int c = 0; c < 4; c++) begin
			result[c] = apply ? q16_mul(item.layer[c], weight) : item.layer[c];
		end
		return result;
	endfunction

	// Channel values lean toward the extremes so rounding and saturation are exercised.
	function automatic logic [CH_W-1:0] random_channel();
		logic [CH_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = CHAN_FULL;
			2: v = CH_W'($urandom_range(0, 255));
			3: v = CHAN_FULL - CH_W'($urandom_range(0, 255));
			default: v = CH_W'($urandom);
		endcase
		return v;
	endfunction

	function automatic matte_item_t random_item();
		matte_item_t item;
		for (int c = 0; c < 4; c++) begin
			item.layer[c] = random_channel();
			item.matte[c] = random_channel();
		end
		item.overlap = ($urandom_range(0, 99) < 85);
		return item;
	endfunction

	function automatic matte_item_t make_item(input logic [CH_W-1:0] layer_val,
			input logic [CH_W-1:0] matte_val, input logic overlap);
		matte_item_t item;
		for (int c = 0; c < 4; c++) begin
			item.layer[c] = layer_val;
			item.matte[c] = matte_val;
		end
		item.overlap = overlap;
		return item;
	endfunction

	task automatic send_pixel(input matte_item_t item);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {item.matte, item.layer};
		s_tuser <= item.overlap;
		do @(posedge clk); while (!s_tready);
		expected_pixels.push_back(weight_layer_pixel(item, active_mode));
	endtask

	// The mode may change only with the pipeline empty.
	task automatic write_matte_mode(input logic [2:0] code);
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_wen <= 1'b0;
		active_mode = code;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected word on output, data %h", $time, m_tdata);
					error_count++;
				end else begin
					pixel_t want;
					pixel_t got;
					want = expected_pixels.pop_front();
					got = m_tdata;
					for (int c = 0; c < 4; c++) begin
						if (got[c] !== want[c]) begin
							$display("%0t: out_%s mismatch on pixel %0d: expected %h, actual %h",
								$time, chan_name[c], pixels_checked, want[c], got[c]);
							error_count++;
						end
					end
					pixels_checked++;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic test_reset_passthrough();
		send_pixel(make_item(CHAN_FULL, '0, 1'b1));
		send_pixel(random_item());
	endtask

	task automatic test_mode_extremes();
		matte_item_t item;
		for (int m = int'(MODE_ALPHA); m <= int'(MODE_INV_LUMA); m++) begin
			write_matte_mode(3'(m));
			send_pixel(make_item(CHAN_FULL, CHAN_FULL, 1'b1));
			send_pixel(make_item(CHAN_FULL, '0, 1'b1));
			item = random_item();
			item.matte[CH_ALPHA] = CHAN_FULL;
			item.overlap = 1'b1;
			send_pixel(item);
			item = random_item();
			item.overlap = 1'b0;
			send_pixel(item);
		end
	endtask

	task automatic test_unused_mode_codes();
		matte_item_t item;
		for (int m = int'(MODE_INV_LUMA) + 1; m < MODE_CODES; m++) begin
			write_matte_mode(3'(m));
			item = random_item();
			item.overlap = 1'b1;
			send_pixel(item);
		end
		write_matte_mode(MODE_NONE);
		send_pixel(make_item(CHAN_FULL, CHAN_FULL, 1'b1));
	endtask

	// Runs segments of random pixels, each under its own mode. The first eight segments
	// of all runs together walk through every mode code; later ones favor the weighting modes.
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int pixel_total);
		int sent;
		int seg_len;
		logic [2:0] code;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < pixel_total) begin
			if (segment_count < MODE_CODES) begin
				code = 3'(segment_count);
			end else if ($urandom_range(0, 99) < 70) begin
				code = 3'($urandom_range(int'(MODE_ALPHA), int'(MODE_INV_LUMA)));
			end else begin
				code = 3'($urandom_range(0, MODE_CODES - 1));
			end
			segment_count++;
			write_matte_mode(code);
			seg_len = $urandom_range(30, 50);
			for (int i = 0; i < seg_len && sent < pixel_total; i++) begin
				send_pixel(random_item());
				sent++;
			end
		end
	endtask

	initial begin
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 27;
		recv_idle_pct = 68;
		test_reset_passthrough();
		test_mode_extremes();
		test_unused_mode_codes();
		test_random_traffic(27, 68, 280);
		test_random_traffic(68, 27, 280);
		test_random_traffic(0, 0, 280);
		s_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
		$display("Checked %0d pixels over %0d mode segments, all eight mode codes,",
			pixels_checked, segment_count);
		$display("inside and outside the overlap, under three stall patterns.");
		if (error_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/tmpu_pkg.sv
rtl/core/track_matte_pixel_unit_core.sv
tb/testbench.sv
